>>> hw/rtl/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg: shared types and constants for the wall-follow navigator
// Operation codes, turn codes, register indexes, the result record and the
// fixed pulse and creep constants.
// ----------------------------------------------------------------------------
package mwf_pkg;

   localparam int SAMPLES_DEF  = 20;
   localparam int MAZE_DIM_DEF = 16;
   localparam int SAMPLE_BITS  = 12;

   localparam int WALL_THR_RST = 8;
   localparam int FAR_THR_RST  = 10;
   localparam int MID_THR_RST  = 7;
   localparam int NEAR_THR_RST = 4;

   localparam int PULSES_PER_DEG = 19;
   localparam int PULSES_PER_MM  = 21;
   localparam logic [11:0] PULSES_90  = 12'(90 * PULSES_PER_DEG);
   localparam logic [11:0] PULSES_180 = 12'(180 * PULSES_PER_DEG);

   localparam logic [5:0]  CREEP_LONG  = 6'd50;
   localparam logic [5:0]  CREEP_MID   = 6'd30;
   localparam logic [5:0]  CREEP_SHORT = 6'd20;
   localparam logic [10:0] CREEP_LONG_PULSES  = 11'(50 * PULSES_PER_MM);
   localparam logic [10:0] CREEP_MID_PULSES   = 11'(30 * PULSES_PER_MM);
   localparam logic [10:0] CREEP_SHORT_PULSES = 11'(20 * PULSES_PER_MM);

   typedef enum logic [1:0] {
      FUNC_SCAN  = 2'd0,
      FUNC_DRIVE = 2'd1,
      FUNC_TURN  = 2'd2,
      FUNC_MAP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      TURN_NONE   = 2'd0,
      TURN_RIGHT  = 2'd1,
      TURN_LEFT   = 2'd2,
      TURN_AROUND = 2'd3
   } turn_type;

   typedef enum logic [2:0] {
      CSR_WALL_THR   = 3'd0,
      CSR_FAR_THR    = 3'd1,
      CSR_MID_THR    = 3'd2,
      CSR_NEAR_THR   = 3'd3,
      CSR_START_X    = 3'd4,
      CSR_START_Y    = 3'd5,
      CSR_START_HEAD = 3'd6
   } csr_index_type;

   // per-lane accumulate control for one beat
   typedef struct packed {
      logic en;       // a scan or drive sample is taken this cycle
      logic restart;  // drop the running sum before adding
      logic add;      // add this lane's sample
      logic flush;    // average is complete, clear after use
   } lane_ctl_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  walls;
      logic        explored;
      logic [1:0]  turn_kind;
      logic [11:0] turn_pulses;
      logic [5:0]  creep_mm;
      logic [10:0] creep_pulses;
      logic [1:0]  heading_now;
      logic [3:0]  col_now;
      logic [3:0]  row_now;
      logic        edge_hit;
   } result_type;

endpackage

>>> hw/rtl/maze_wall_follow_navigator_top.sv
// ----------------------------------------------------------------------------
// maze_wall_follow_navigator_top: right-hand wall-follow maze navigator
// Three sensor lanes average distance samples; a merge stage turns them into
// wall maps, turns, creeps and position moves, backed by a per-cell map RAM.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while req_tready is high and answers in
// the cycle after the beat is taken; a scan or drive sample that does not
// finish its average gives no response. Throughput is set by the single
// output register, which is freed in the same cycle the response is taken,
// so req_tready follows rsp_tready. Map reads come from the map RAM's
// registered read port. After reset the block sweeps the map RAM to clear
// it, one cell a cycle over all MAZE_DIM*MAZE_DIM cells, with req_tready
// low; register writes are taken during the sweep.
module maze_wall_follow_navigator_top #(
   parameter int SAMPLES  = mwf_pkg::SAMPLES_DEF,
   parameter int MAZE_DIM = mwf_pkg::MAZE_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = func[1:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: dist_front[11:0], dist_left[23:12], dist_right[35:24],
   //        target_heading[37:36], cell_col[41:38], cell_row[45:42], zero pad
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   // response: tuser = kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: walls[3:0], explored[4], turn_kind[6:5], turn_pulses[18:7],
   //        creep_mm[24:19], creep_pulses[35:25], heading_now[37:36],
   //        col_now[41:38], row_now[45:42], edge_hit[46], zero pad
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int POS_W  = $clog2(MAZE_DIM);
   localparam int DEPTH  = MAZE_DIM * MAZE_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(SAMPLES + 1);
   localparam int SUM_W  = mwf_pkg::SAMPLE_BITS + CNT_W;
   localparam int SB     = mwf_pkg::SAMPLE_BITS;

   // input fields
   mwf_pkg::func_type func;
   logic [SB-1:0] dist_front, dist_left, dist_right;
   logic [1:0]    target_heading;
   logic [3:0]    cell_col, cell_row;

   assign func           = mwf_pkg::func_type'(req_tuser);
   assign dist_front     = req_tdata[11:0];
   assign dist_left      = req_tdata[23:12];
   assign dist_right     = req_tdata[35:24];
   assign target_heading = req_tdata[37:36];
   assign cell_col       = req_tdata[41:38];
   assign cell_row       = req_tdata[45:42];

   // state
   logic [1:0]       heading_ff, heading_in;
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             acc_kind_ff, acc_kind_in;
   logic [SUM_W-1:0] wall_lim_ff, far_lim_ff, mid_lim_ff, near_lim_ff;
   logic             clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   mwf_pkg::result_type res_ff;
   logic             map_ff, map_ok_ff;

   logic accept;
   logic is_sample;
   logic restart;
   logic [CNT_W-1:0] count_next;
   logic final_sample;

   assign req_tready = !clr_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_sample  = (func == mwf_pkg::FUNC_SCAN) || (func == mwf_pkg::FUNC_DRIVE);
   // a sample of the other kind restarts the averaging
   assign restart    = acc_kind_ff != func[0];
   assign count_next = (restart ? '0 : count_ff) + CNT_W'(1);
   assign final_sample = count_next == CNT_W'(SAMPLES);

   // lanes
   mwf_pkg::lane_ctl_type ctl_front, ctl_side;
   logic [SUM_W-1:0] sum_front, sum_left, sum_right;
   logic wall_front, wall_left, wall_right;

   always_comb begin
      ctl_front.en      = accept && is_sample;
      ctl_front.restart = restart;
      ctl_front.add     = 1'b1;
      ctl_front.flush   = final_sample;
      ctl_side          = ctl_front;
      ctl_side.add      = func == mwf_pkg::FUNC_SCAN;
   end

   mwf_lane #(.SUM_W(SUM_W)) u_lane_front (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_front),
      .sample   (dist_front),
      .wall_lim (wall_lim_ff),
      .sum_next (sum_front),
      .is_wall  (wall_front)
   );

   mwf_lane #(.SUM_W(SUM_W)) u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_side),
      .sample   (dist_left),
      .wall_lim (wall_lim_ff),
      .sum_next (sum_left),
      .is_wall  (wall_left)
   );

   mwf_lane #(.SUM_W(SUM_W)) u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_side),
      .sample   (dist_right),
      .wall_lim (wall_lim_ff),
      .sum_next (sum_right),
      .is_wall  (wall_right)
   );

   // merge
   mwf_pkg::result_type res;
   logic             emit, map_we;
   logic [4:0]       map_wdata;
   logic [1:0]       heading_nx;
   logic [POS_W-1:0] col_nx, row_nx;

   mwf_merge #(.MAZE_DIM(MAZE_DIM), .SUM_W(SUM_W)) u_merge (
      .func           (func),
      .final_sample   (final_sample),
      .target_heading (target_heading),
      .heading        (heading_ff),
      .col_pos        (col_ff),
      .row_pos        (row_ff),
      .wall_front     (wall_front),
      .wall_left      (wall_left),
      .wall_right     (wall_right),
      .front_sum      (sum_front),
      .far_lim        (far_lim_ff),
      .mid_lim        (mid_lim_ff),
      .near_lim       (near_lim_ff),
      .res            (res),
      .emit           (emit),
      .map_we         (map_we),
      .map_wdata      (map_wdata),
      .heading_nx     (heading_nx),
      .col_nx         (col_nx),
      .row_nx         (row_nx)
   );

   // map RAM
   logic              ram_we, ram_re, map_ok;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [4:0]        ram_wdata, ram_rdata;

   assign map_ok    = (32'(cell_col) < MAZE_DIM) && (32'(cell_row) < MAZE_DIM);
   assign ram_raddr = ADDR_W'(32'(cell_col) * MAZE_DIM + 32'(cell_row));
   assign ram_re    = accept && (func == mwf_pkg::FUNC_MAP);
   assign ram_we    = clr_busy_ff || (accept && map_we);
   assign ram_waddr = clr_busy_ff ? clr_addr_ff
                                  : ADDR_W'(32'(col_ff) * MAZE_DIM + 32'(row_ff));
   assign ram_wdata = clr_busy_ff ? '0 : map_wdata;

   mwf_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      heading_in  = heading_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      count_in    = count_ff;
      acc_kind_in = acc_kind_ff;
      if (accept) begin
         heading_in = heading_nx;
         col_in     = col_nx;
         row_in     = row_nx;
         if (is_sample) begin
            acc_kind_in = func[0];
            count_in    = final_sample ? '0 : count_next;
         end
      end
      if (csr_we) begin
         unique case (mwf_pkg::csr_index_type'(csr_addr))
            mwf_pkg::CSR_START_X: begin
               col_in = (32'(csr_wdata[3:0]) >= MAZE_DIM) ? POS_W'(MAZE_DIM - 1)
                                                          : POS_W'(csr_wdata[3:0]);
            end
            mwf_pkg::CSR_START_Y: begin
               row_in = (32'(csr_wdata[3:0]) >= MAZE_DIM) ? POS_W'(MAZE_DIM - 1)
                                                          : POS_W'(csr_wdata[3:0]);
            end
            mwf_pkg::CSR_START_HEAD: heading_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = (accept && emit) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         acc_kind_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         wall_lim_ff  <= SUM_W'((mwf_pkg::WALL_THR_RST + 1) * SAMPLES);
         far_lim_ff   <= SUM_W'((mwf_pkg::FAR_THR_RST + 1) * SAMPLES);
         mid_lim_ff   <= SUM_W'(mwf_pkg::MID_THR_RST * SAMPLES);
         near_lim_ff  <= SUM_W'(mwf_pkg::NEAR_THR_RST * SAMPLES);
      end else begin
         heading_ff   <= heading_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         acc_kind_ff  <= acc_kind_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         // store limits pre-scaled by the sample count
         if (csr_we) begin
            unique case (mwf_pkg::csr_index_type'(csr_addr))
               mwf_pkg::CSR_WALL_THR:
                  wall_lim_ff <= SUM_W'((32'(csr_wdata) + 32'd1) * SAMPLES);
               mwf_pkg::CSR_FAR_THR:
                  far_lim_ff  <= SUM_W'((32'(csr_wdata) + 32'd1) * SAMPLES);
               mwf_pkg::CSR_MID_THR:
                  mid_lim_ff  <= SUM_W'(32'(csr_wdata) * SAMPLES);
               mwf_pkg::CSR_NEAR_THR:
                  near_lim_ff <= SUM_W'(32'(csr_wdata) * SAMPLES);
               default: ;
            endcase
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         res_ff    <= res;
         map_ff    <= func == mwf_pkg::FUNC_MAP;
         map_ok_ff <= map_ok;
      end
   end

   mwf_pkg::result_type rsp;

   always_comb begin
      rsp = res_ff;
      if (map_ff) begin
         rsp.walls    = map_ok_ff ? ram_rdata[3:0] : 4'd0;
         rsp.explored = map_ok_ff ? ram_rdata[4] : 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp.kind;
   assign rsp_tdata  = {1'b0, rsp.edge_hit, rsp.row_now, rsp.col_now, rsp.heading_now,
                        rsp.creep_pulses, rsp.creep_mm, rsp.turn_pulses, rsp.turn_kind,
                        rsp.explored, rsp.walls};

endmodule

>>> hw/rtl/mwf_ram.sv
// ----------------------------------------------------------------------------
// mwf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mwf_lane.sv
// ----------------------------------------------------------------------------
// mwf_lane: one distance sensor lane
// Accumulates the samples of one sensor and compares the running sum with
// the scaled wall limit, so no divide by the sample count is needed.
// ----------------------------------------------------------------------------
module mwf_lane #(
   parameter int SUM_W = 17
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mwf_pkg::lane_ctl_type            ctl,
   input  logic [mwf_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic [SUM_W-1:0]                 wall_lim,
   output logic [SUM_W-1:0]                 sum_next,
   output logic                             is_wall
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] addend;

   assign base     = ctl.restart ? '0 : sum_ff;
   assign addend   = ctl.add ? SUM_W'(sample) : '0;
   assign sum_next = base + addend;
   // average <= threshold  <=>  sum < (threshold + 1) * SAMPLES
   assign is_wall  = sum_next < wall_lim;

   always_comb begin
      sum_in = sum_ff;
      if (ctl.en) begin
         sum_in = ctl.flush ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

>>> hw/rtl/mwf_merge.sv
// ----------------------------------------------------------------------------
// mwf_merge: combine lane findings into a navigation step
// Rotates wall bits into compass order, picks the right-hand turn, picks the
// creep distance, moves and clamps the position, and forms the result.
// ----------------------------------------------------------------------------
module mwf_merge #(
   parameter int MAZE_DIM = 16,
   parameter int SUM_W    = 17
) (
   input  mwf_pkg::func_type               func,
   input  logic                            final_sample,
   input  logic [1:0]                      target_heading,
   input  logic [1:0]                      heading,
   input  logic [$clog2(MAZE_DIM)-1:0]     col_pos,
   input  logic [$clog2(MAZE_DIM)-1:0]     row_pos,
   input  logic                            wall_front,
   input  logic                            wall_left,
   input  logic                            wall_right,
   input  logic [SUM_W-1:0]                front_sum,
   input  logic [SUM_W-1:0]                far_lim,
   input  logic [SUM_W-1:0]                mid_lim,
   input  logic [SUM_W-1:0]                near_lim,
   output mwf_pkg::result_type             res,
   output logic                            emit,
   output logic                            map_we,
   output logic [4:0]                      map_wdata,
   output logic [1:0]                      heading_nx,
   output logic [$clog2(MAZE_DIM)-1:0]     col_nx,
   output logic [$clog2(MAZE_DIM)-1:0]     row_nx
);

   localparam int POS_W = $clog2(MAZE_DIM);
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAZE_DIM - 1);

   logic [3:0] rel_walls;
   logic [3:0] abs_walls;
   logic [1:0] delta;

   // relative order: front, right, rear (always open), left
   assign rel_walls = {wall_left, 1'b0, wall_right, wall_front};
   assign delta     = target_heading - heading;

   always_comb begin
      abs_walls = '0;
      for (int k = 0; k < 4; k++) begin
         abs_walls[2'(heading + 2'(k))] = rel_walls[k];
      end
   end

   always_comb begin
      res        = '0;
      res.kind   = func;
      emit       = 1'b0;
      map_we     = 1'b0;
      map_wdata  = {1'b1, abs_walls};
      heading_nx = heading;
      col_nx     = col_pos;
      row_nx     = row_pos;
      unique case (func)
         mwf_pkg::FUNC_SCAN: begin
            if (final_sample) begin
               emit         = 1'b1;
               map_we       = 1'b1;
               res.walls    = abs_walls;
               res.explored = 1'b1;
               if (!wall_right) begin
                  res.turn_kind   = mwf_pkg::TURN_RIGHT;
                  res.turn_pulses = mwf_pkg::PULSES_90;
                  heading_nx      = heading + 2'd1;
               end else if (!wall_front) begin
                  res.turn_kind = mwf_pkg::TURN_NONE;
               end else if (!wall_left) begin
                  res.turn_kind   = mwf_pkg::TURN_LEFT;
                  res.turn_pulses = mwf_pkg::PULSES_90;
                  heading_nx      = heading + 2'd3;
               end else begin
                  res.turn_kind   = mwf_pkg::TURN_AROUND;
                  res.turn_pulses = mwf_pkg::PULSES_180;
                  heading_nx      = heading + 2'd2;
               end
            end
         end
         mwf_pkg::FUNC_DRIVE: begin
            if (final_sample) begin
               emit = 1'b1;
               // first test that holds decides
               if (front_sum >= far_lim) begin
                  res.creep_mm     = mwf_pkg::CREEP_LONG;
                  res.creep_pulses = mwf_pkg::CREEP_LONG_PULSES;
               end else if (front_sum >= mid_lim) begin
                  res.creep_mm     = mwf_pkg::CREEP_MID;
                  res.creep_pulses = mwf_pkg::CREEP_MID_PULSES;
               end else if (front_sum >= near_lim) begin
                  res.creep_mm     = mwf_pkg::CREEP_SHORT;
                  res.creep_pulses = mwf_pkg::CREEP_SHORT_PULSES;
               end
               case (heading)
                  2'd0: begin
                     if (row_pos >= POS_TOP) res.edge_hit = 1'b1;
                     else row_nx = row_pos + POS_W'(1);
                  end
                  2'd1: begin
                     if (col_pos >= POS_TOP) res.edge_hit = 1'b1;
                     else col_nx = col_pos + POS_W'(1);
                  end
                  2'd2: begin
                     if (row_pos == '0) res.edge_hit = 1'b1;
                     else row_nx = row_pos - POS_W'(1);
                  end
                  default: begin
                     if (col_pos == '0) res.edge_hit = 1'b1;
                     else col_nx = col_pos - POS_W'(1);
                  end
               endcase
            end
         end
         mwf_pkg::FUNC_TURN: begin
            emit       = 1'b1;
            heading_nx = target_heading;
            // opposite target: heading set with no turn command
            if (delta == 2'd1) begin
               res.turn_kind   = mwf_pkg::TURN_RIGHT;
               res.turn_pulses = mwf_pkg::PULSES_90;
            end else if (delta == 2'd3) begin
               res.turn_kind   = mwf_pkg::TURN_LEFT;
               res.turn_pulses = mwf_pkg::PULSES_90;
            end
         end
         mwf_pkg::FUNC_MAP: begin
            emit = 1'b1;
         end
      endcase
      res.heading_now = heading_nx;
      res.col_now     = 4'(col_nx);
      res.row_now     = 4'(row_nx);
   end

endmodule

>>> hw/rtl/mwf_checker.sv
// ----------------------------------------------------------------------------
// mwf_checker: port-level checks for the wall-follow navigator
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module mwf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_we
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // map clear sweep keeps the request side closed right after reset
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or response shown right after reset");

   // a fast turn answers next cycle with the target as the new heading
   a_turn_heading: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser == mwf_pkg::FUNC_TURN) && !csr_we |=>
         rsp_tvalid && (rsp_tuser == mwf_pkg::FUNC_TURN) &&
         (rsp_tdata[37:36] == $past(req_tdata[37:36])))
      else $error("fast turn response missing or wrong heading");

   // a map read always answers next cycle
   a_map_answer: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_tuser == mwf_pkg::FUNC_MAP) |=>
         rsp_tvalid && (rsp_tuser == mwf_pkg::FUNC_MAP))
      else $error("map read response missing");

endmodule

bind maze_wall_follow_navigator_top mwf_checker u_mwf_checker (.*);
